### rtl/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and constants for the calendar clock: the item and result
// payloads, the calendar record passed between units and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

    // configuration register map
    typedef enum logic [1:0] {
        CFG_TICKS_PER_SECOND = 2'd0,
        CFG_BINARY_FORMAT    = 2'd1,
        CFG_HOUR_24_FORMAT   = 2'd2,
        CFG_UNUSED           = 2'd3
    } cfg_index_t;

    // item operations
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;
    localparam logic        BINARY_FORMAT_RESET    = 1'b0;
    localparam logic        HOUR_24_FORMAT_RESET   = 1'b1;

    localparam logic [5:0]  MAX_SECOND = 6'd59;
    localparam logic [5:0]  MAX_MINUTE = 6'd59;
    localparam logic [4:0]  MAX_HOUR   = 5'd23;
    localparam logic [3:0]  MAX_MONTH  = 4'd12;
    localparam logic [13:0] MAX_YEAR   = 14'd9999;
    localparam logic [6:0]  MAX_YR_PART = 7'd99;

    typedef struct packed {
        logic       operation;
        logic [7:0] rtc_second;
        logic [7:0] rtc_minute;
        logic [7:0] rtc_hour;
        logic [7:0] rtc_day;
        logic [7:0] rtc_month;
        logic [7:0] rtc_year;
        logic [7:0] rtc_century;
    } item_t;

    typedef struct packed {
        logic [5:0]  cur_second;
        logic [5:0]  cur_minute;
        logic [4:0]  cur_hour;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        logic [63:0] elapsed_seconds;
        logic [31:0] tick_total;
    } result_t;

    // calendar record; the year is also kept split as year / 100 and
    // year % 100 so the leap test needs no division
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  yr_hi;
        logic [6:0]  yr_lo;
    } cal_t;

    localparam cal_t CAL_RESET = '{
        second: 6'd0,
        minute: 6'd0,
        hour:   5'd0,
        day:    5'd1,
        month:  4'd1,
        year:   14'd1970,
        yr_hi:  7'd19,
        yr_lo:  7'd70
    };

endpackage

`default_nettype wire

### rtl/rtc_load_decode.sv
// ----------------------------------------------------------------------------
// rtc_load_decode
// Turns raw RTC bytes into a clamped calendar record (BCD or binary input,
// 12-hour to 24-hour conversion, century and year combined).
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_load_decode (
    input  var rtc_pkg::item_t item,
    input  var logic           binary_format,
    input  var logic           hour_24_format,
    output var rtc_pkg::cal_t  cal
);

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'b0000, b[7:4]} * 8'd10;
        return {4'b0000, b[3:0]} + tens;
    endfunction

    // value is at most 139, so five conditional subtracts cover it
    function automatic logic [7:0] mod24(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        for (int i = 0; i < 5; i++)
        begin
            if (r >= 8'd24)
            begin
                r = r - 8'd24;
            end
        end
        return r;
    endfunction

    logic [7:0]  sec_b;
    logic [7:0]  min_b;
    logic [7:0]  hour_b;
    logic [7:0]  hour_c;
    logic [7:0]  day_b;
    logic [7:0]  month_b;
    logic [7:0]  yy_b;
    logic [7:0]  cc_b;
    logic [6:0]  hour_lo;
    logic [15:0] full_year;
    logic [1:0]  yy_q;
    logic [7:0]  yy_rem;
    logic [8:0]  hi_sum;

    always_comb
    begin
        // three tens bits, pm flag kept in bit 7
        hour_lo = 7'({4'b0000, item.rtc_hour[3:0]}
                     + ({5'b00000, item.rtc_hour[6:4]} * 8'd10));

        if (binary_format)
        begin
            sec_b   = item.rtc_second;
            min_b   = item.rtc_minute;
            hour_b  = item.rtc_hour;
            day_b   = item.rtc_day;
            month_b = item.rtc_month;
            yy_b    = item.rtc_year;
            cc_b    = item.rtc_century;
        end
        else
        begin
            sec_b   = bcd_to_bin(item.rtc_second);
            min_b   = bcd_to_bin(item.rtc_minute);
            hour_b  = {item.rtc_hour[7], hour_lo};
            day_b   = bcd_to_bin(item.rtc_day);
            month_b = bcd_to_bin(item.rtc_month);
            yy_b    = bcd_to_bin(item.rtc_year);
            cc_b    = bcd_to_bin(item.rtc_century);
        end

        if (!hour_24_format && hour_b[7])
        begin
            hour_c = mod24({1'b0, hour_b[6:0]} + 8'd12);
        end
        else
        begin
            hour_c = hour_b;
        end

        cal.second = (sec_b > 8'(rtc_pkg::MAX_SECOND)) ? rtc_pkg::MAX_SECOND : sec_b[5:0];
        cal.minute = (min_b > 8'(rtc_pkg::MAX_MINUTE)) ? rtc_pkg::MAX_MINUTE : min_b[5:0];
        cal.hour   = (hour_c > 8'(rtc_pkg::MAX_HOUR)) ? rtc_pkg::MAX_HOUR : hour_c[4:0];

        if (day_b == 8'd0)
        begin
            cal.day = 5'd1;
        end
        else if (day_b > 8'd31)
        begin
            cal.day = 5'd31;
        end
        else
        begin
            cal.day = day_b[4:0];
        end

        if (month_b == 8'd0)
        begin
            cal.month = 4'd1;
        end
        else if (month_b > 8'(rtc_pkg::MAX_MONTH))
        begin
            cal.month = rtc_pkg::MAX_MONTH;
        end
        else
        begin
            cal.month = month_b[3:0];
        end

        // century * 100 + year, clamped
        full_year = ({8'h00, cc_b} * 16'd100) + {8'h00, yy_b};
        cal.year  = (full_year > 16'(rtc_pkg::MAX_YEAR)) ? rtc_pkg::MAX_YEAR : full_year[13:0];

        // split into hundreds and remainder for the leap test
        if (yy_b >= 8'd200)
        begin
            yy_q   = 2'd2;
            yy_rem = yy_b - 8'd200;
        end
        else if (yy_b >= 8'd100)
        begin
            yy_q   = 2'd1;
            yy_rem = yy_b - 8'd100;
        end
        else
        begin
            yy_q   = 2'd0;
            yy_rem = yy_b;
        end
        hi_sum = {1'b0, cc_b} + {7'd0, yy_q};
        if (hi_sum > 9'(rtc_pkg::MAX_YR_PART))
        begin
            cal.yr_hi = rtc_pkg::MAX_YR_PART;
            cal.yr_lo = rtc_pkg::MAX_YR_PART;
        end
        else
        begin
            cal.yr_hi = hi_sum[6:0];
            cal.yr_lo = yy_rem[6:0];
        end
    end

endmodule

`default_nettype wire

### rtl/rtc_time_advance.sv
// ----------------------------------------------------------------------------
// rtc_time_advance
// Moves a calendar record on by one second with Gregorian leap years.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_time_advance (
    input  var rtc_pkg::cal_t cur,
    output var rtc_pkg::cal_t nxt
);

    logic       leap;
    logic [4:0] month_len;

    always_comb
    begin
        // year % 4 follows year % 100 since 100 is a multiple of 4
        if (cur.yr_lo == 7'd0)
        begin
            leap = (cur.yr_hi[1:0] == 2'b00);
        end
        else
        begin
            leap = (cur.yr_lo[1:0] == 2'b00);
        end

        case (cur.month) inside
            4'd2:
            begin
                month_len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11:
            begin
                month_len = 5'd30;
            end
            default:
            begin
                month_len = 5'd31;
            end
        endcase

        nxt = cur;
        if (cur.second < rtc_pkg::MAX_SECOND)
        begin
            nxt.second = cur.second + 6'd1;
        end
        else
        begin
            nxt.second = 6'd0;
            if (cur.minute < rtc_pkg::MAX_MINUTE)
            begin
                nxt.minute = cur.minute + 6'd1;
            end
            else
            begin
                nxt.minute = 6'd0;
                if (cur.hour < rtc_pkg::MAX_HOUR)
                begin
                    nxt.hour = cur.hour + 5'd1;
                end
                else
                begin
                    nxt.hour = 5'd0;
                    if (cur.day < month_len)
                    begin
                        nxt.day = cur.day + 5'd1;
                    end
                    else
                    begin
                        nxt.day = 5'd1;
                        if (cur.month < rtc_pkg::MAX_MONTH)
                        begin
                            nxt.month = cur.month + 4'd1;
                        end
                        else
                        begin
                            nxt.month = 4'd1;
                            if (cur.year >= rtc_pkg::MAX_YEAR)
                            begin
                                nxt.year  = 14'd0;
                                nxt.yr_hi = 7'd0;
                                nxt.yr_lo = 7'd0;
                            end
                            else
                            begin
                                nxt.year = cur.year + 14'd1;
                                if (cur.yr_lo == rtc_pkg::MAX_YR_PART)
                                begin
                                    nxt.yr_lo = 7'd0;
                                    nxt.yr_hi = cur.yr_hi + 7'd1;
                                end
                                else
                                begin
                                    nxt.yr_lo = cur.yr_lo + 7'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/rtc_calendar_clock.sv
// ----------------------------------------------------------------------------
// rtc_calendar_clock
// Millisecond-driven calendar clock, loadable from raw RTC bytes.
// ----------------------------------------------------------------------------
// an accepted item is held in the input register, then written into the
//   state / result register when the result slot is free or being emptied
// throughput: one item per cycle while the result channel does not stall
// reset: calendar 1970-01-01 00:00:00, all counters zero, ticks_per_second
//   1000, BCD input, 24-hour input; no clearing pass, ready right after reset
`default_nettype none

module rtc_calendar_clock (
    input  var logic             clk,
    input  var logic             rst_n,
    // item channel
    input  var logic             item_valid,
    output var logic             item_ready,
    input  var rtc_pkg::item_t   item,
    // result channel
    output var logic             result_valid,
    input  var logic             result_ready,
    output var rtc_pkg::result_t result,
    // configuration write channel
    input  var logic             cfg_valid,
    output var logic             cfg_ready,
    input  var logic [1:0]       cfg_index,
    input  var logic [15:0]      cfg_data
);

    // configuration registers
    logic [15:0] tps_reg;
    logic        binary_format_reg;
    logic        hour_24_format_reg;

    // input register
    logic           item_valid_reg;
    rtc_pkg::item_t item_reg;

    // clock state; these registers also are the result register, since
    // they only change when a new result is written
    logic [15:0]   prescale_reg;
    logic [15:0]   prescale_next;
    logic [31:0]   tick_reg;
    logic [31:0]   tick_next;
    logic [63:0]   seconds_reg;
    logic [63:0]   seconds_next;
    rtc_pkg::cal_t cal_reg;
    rtc_pkg::cal_t cal_next;
    logic          result_valid_reg;

    rtc_pkg::cal_t cal_loaded;
    rtc_pkg::cal_t cal_stepped;
    logic [15:0]   prescale_inc;
    logic          second_done;
    logic          advance;

    // result slot free or being emptied this cycle
    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = !item_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg            <= rtc_pkg::TICKS_PER_SECOND_RESET;
            binary_format_reg  <= rtc_pkg::BINARY_FORMAT_RESET;
            hour_24_format_reg <= rtc_pkg::HOUR_24_FORMAT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (rtc_pkg::cfg_index_t'(cfg_index))
                rtc_pkg::CFG_TICKS_PER_SECOND:
                begin
                    tps_reg <= cfg_data;
                end
                rtc_pkg::CFG_BINARY_FORMAT:
                begin
                    binary_format_reg <= cfg_data[0];
                end
                rtc_pkg::CFG_HOUR_24_FORMAT:
                begin
                    hour_24_format_reg <= cfg_data[0];
                end
                default:
                begin
                    // writes to unmapped indexes are dropped
                end
            endcase
        end
    end

    // input register, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    // input register, payload part
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    rtc_load_decode u_load_decode (
        .item           (item_reg),
        .binary_format  (binary_format_reg),
        .hour_24_format (hour_24_format_reg),
        .cal            (cal_loaded)
    );

    rtc_time_advance u_time_advance (
        .cur (cal_reg),
        .nxt (cal_stepped)
    );

    // a zero ticks_per_second makes every tick a second, as the compare
    // below is always true then
    assign prescale_inc = prescale_reg + 16'd1;
    assign second_done  = (prescale_inc >= tps_reg);

    always_comb
    begin
        prescale_next = prescale_reg;
        tick_next     = tick_reg;
        seconds_next  = seconds_reg;
        cal_next      = cal_reg;
        if (item_reg.operation == rtc_pkg::OP_LOAD)
        begin
            // counters keep running state across a load
            cal_next = cal_loaded;
        end
        else
        begin
            tick_next = tick_reg + 32'd1;
            if (second_done)
            begin
                prescale_next = 16'd0;
                seconds_next  = seconds_reg + 64'd1;
                cal_next      = cal_stepped;
            end
            else
            begin
                prescale_next = prescale_inc;
            end
        end
    end

    // state and result update, one item per cycle while the result slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            prescale_reg     <= 16'd0;
            tick_reg         <= 32'd0;
            seconds_reg      <= 64'd0;
            cal_reg          <= rtc_pkg::CAL_RESET;
        end
        else if (advance)
        begin
            result_valid_reg <= item_valid_reg;
            if (item_valid_reg)
            begin
                prescale_reg <= prescale_next;
                tick_reg     <= tick_next;
                seconds_reg  <= seconds_next;
                cal_reg      <= cal_next;
            end
        end
    end

    assign result_valid           = result_valid_reg;
    assign result.cur_second      = cal_reg.second;
    assign result.cur_minute      = cal_reg.minute;
    assign result.cur_hour        = cal_reg.hour;
    assign result.cur_day         = cal_reg.day;
    assign result.cur_month       = cal_reg.month;
    assign result.cur_year        = cal_reg.year;
    assign result.elapsed_seconds = seconds_reg;
    assign result.tick_total      = tick_reg;

endmodule

`default_nettype wire

### tb/tb_rtc_calendar_clock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtc_calendar_clock
// Self-checking bench for the calendar clock. A behavioral copy of the clock
// runs beside the block and predicts the reading after every accepted item.
// Directed checks cover the prescaler, load clamping, BCD decoding, 12-hour
// conversion and the calendar rollovers. Constrained-by-hand random traffic
// then runs under several register settings and idle patterns.
// ----------------------------------------------------------------------------

module tb_rtc_calendar_clock;

    // ------------------------------------------------------------------------
    // block signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    rtc_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    rtc_pkg::result_t result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index    = rtc_pkg::CFG_TICKS_PER_SECOND;
    logic [15:0]      cfg_data     = '0;

    rtc_calendar_clock dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // clock: 10 ns period
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // shared bench state
    // ------------------------------------------------------------------------
    rtc_pkg::result_t expected_readings[$];   // predicted readings, oldest first
    int      error_count    = 0;
    int      send_idle_pct  = 0;     // chance per cycle that the sender holds off
    int      recv_stall_pct = 0;     // chance per cycle that the receiver stalls
    int      hold_request   = 0;     // long receiver hold, in cycles
    logic    rx_hold        = 1'b0;

    // shadow copy of the configuration registers
    logic [15:0] ticks_per_sec = rtc_pkg::TICKS_PER_SECOND_RESET;
    logic        binary_mode   = rtc_pkg::BINARY_FORMAT_RESET;
    logic        hour24_mode   = rtc_pkg::HOUR_24_FORMAT_RESET;

    // predicted clock state
    logic [15:0] prescale     = '0;
    logic [31:0] tick_count   = '0;
    logic [63:0] second_count = '0;
    logic [5:0]  now_sec      = 6'd0;
    logic [5:0]  now_min      = 6'd0;
    logic [4:0]  now_hour     = 5'd0;
    logic [4:0]  now_day      = 5'd1;
    logic [3:0]  now_month    = 4'd1;
    logic [13:0] now_year     = 14'd1970;

    // ------------------------------------------------------------------------
    // mismatch reporting, one line per mismatch
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // calendar arithmetic
    // ------------------------------------------------------------------------
    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int m, input int y);
        case (m)
            2:              return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    function automatic int bcd_value(input logic [7:0] b);
        return int'(b[3:0]) + int'(b[7:4]) * 10;
    endfunction

    // one second forward, carrying through to the year
    function automatic void advance_one_second();
        if (now_sec < rtc_pkg::MAX_SECOND)
        begin
            now_sec++;
            return;
        end
        now_sec = 6'd0;
        if (now_min < rtc_pkg::MAX_MINUTE)
        begin
            now_min++;
            return;
        end
        now_min = 6'd0;
        if (now_hour < rtc_pkg::MAX_HOUR)
        begin
            now_hour++;
            return;
        end
        now_hour = 5'd0;
        // a loaded day past the month end also rolls to the first
        if (now_day < days_in_month(now_month, now_year))
        begin
            now_day++;
            return;
        end
        now_day = 5'd1;
        if (now_month < rtc_pkg::MAX_MONTH)
        begin
            now_month++;
            return;
        end
        now_month = 4'd1;
        now_year  = (now_year >= rtc_pkg::MAX_YEAR) ? 14'd0 : now_year + 14'd1;
    endfunction

    // decode the raw rtc bytes and clamp them into the calendar
    function automatic void load_calendar_bytes(input rtc_pkg::item_t it);
        int unsigned s, mi, h, d, mo, y, c;
        s  = it.rtc_second;
        mi = it.rtc_minute;
        h  = it.rtc_hour;
        d  = it.rtc_day;
        mo = it.rtc_month;
        y  = it.rtc_year;
        c  = it.rtc_century;
        if (!binary_mode)
        begin
            s  = bcd_value(it.rtc_second);
            mi = bcd_value(it.rtc_minute);
            // the pm flag in bit 7 survives the decode
            h  = int'(it.rtc_hour[3:0]) + int'(it.rtc_hour[6:4]) * 10
                 + (it.rtc_hour[7] ? 128 : 0);
            d  = bcd_value(it.rtc_day);
            mo = bcd_value(it.rtc_month);
            y  = bcd_value(it.rtc_year);
            c  = bcd_value(it.rtc_century);
        end
        // 12 without pm stays 12, 12 pm becomes 0
        if (!hour24_mode && (h & 128) != 0)
            h = ((h & 127) + 12) % 24;
        y = c * 100 + y;
        now_sec   = (s > 59) ? 59 : s;
        now_min   = (mi > 59) ? 59 : mi;
        now_hour  = (h > 23) ? 23 : h;
        now_day   = (d < 1) ? 1 : ((d > 31) ? 31 : d);
        now_month = (mo < 1) ? 1 : ((mo > 12) ? 12 : mo);
        now_year  = (y > 9999) ? 9999 : y;
    endfunction

    // update the predicted state for one accepted item and return the reading
    function automatic rtc_pkg::result_t predict_reading(input rtc_pkg::item_t it);
        rtc_pkg::result_t r;
        if (it.operation == rtc_pkg::OP_TICK)
        begin
            tick_count++;
            prescale++;
            // a zero or lowered rate completes the second right away
            if (prescale >= ticks_per_sec)
            begin
                prescale = '0;
                second_count++;
                advance_one_second();
            end
        end
        else
        begin
            // load leaves every counter alone
            load_calendar_bytes(it);
        end
        r.cur_second      = now_sec;
        r.cur_minute      = now_min;
        r.cur_hour        = now_hour;
        r.cur_day         = now_day;
        r.cur_month       = now_month;
        r.cur_year        = now_year;
        r.elapsed_seconds = second_count;
        r.tick_total      = tick_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic rtc_pkg::item_t load_bytes(input logic [7:0] s, mi, h, d, mo, y, c);
        rtc_pkg::item_t it;
        it.operation   = rtc_pkg::OP_LOAD;
        it.rtc_second  = s;
        it.rtc_minute  = mi;
        it.rtc_hour    = h;
        it.rtc_day     = d;
        it.rtc_month   = mo;
        it.rtc_year    = y;
        it.rtc_century = c;
        return it;
    endfunction

    // random payload bytes; the caller picks the operation
    function automatic rtc_pkg::item_t noise_item(input logic op);
        logic [63:0]    bits;
        rtc_pkg::item_t it;
        bits = {$urandom, $urandom};
        it = bits[$bits(rtc_pkg::item_t)-1:0];
        it.operation = op;
        return it;
    endfunction

    // encode a value 0..99 the way the current format expects
    function automatic logic [7:0] rtc_byte(input int v);
        logic [7:0] b;
        b = v;
        if (!binary_mode)
        begin
            b[7:4] = v / 10;
            b[3:0] = v % 10;
        end
        return b;
    endfunction

    function automatic logic [7:0] hour_byte(input int hr);
        int         raw;
        logic       pm;
        logic [7:0] b;
        raw = hr;
        pm  = 1'b0;
        if (!hour24_mode)
        begin
            if (hr == 0)
            begin
                raw = 12;
                pm  = 1'b1;
            end
            else if (hr > 12)
            begin
                raw = hr - 12;
                pm  = 1'b1;
            end
        end
        b = rtc_byte(raw);
        b[7] = pm;
        return b;
    endfunction

    function automatic rtc_pkg::item_t calendar_item(input int yr, mo, dy, hr, mi, sc);
        return load_bytes(rtc_byte(sc), rtc_byte(mi), hour_byte(hr), rtc_byte(dy),
                          rtc_byte(mo), rtc_byte(yr % 100), rtc_byte(yr / 100));
    endfunction

    // mostly ticks; loads are either raw noise or a well-formed date close to
    // a rollover so that following ticks carry deep into the calendar
    function automatic rtc_pkg::item_t random_item();
        int pick, yr, mo, dy, hr, mi, sc;
        pick = $urandom_range(99);
        if (pick < 65)
            return noise_item(rtc_pkg::OP_TICK);
        if (pick < 80)
            return noise_item(rtc_pkg::OP_LOAD);
        case ($urandom_range(3))
            0:       yr = $urandom_range(9999);
            1:       yr = 9999;
            2:       yr = $urandom_range(99) * 100;
            default: yr = 1970 + $urandom_range(99);
        endcase
        mo = ($urandom_range(2) == 0) ? 12 : $urandom_range(1, 12);
        dy = $urandom_range(1) ? days_in_month(mo, yr) : $urandom_range(1, 31);
        hr = $urandom_range(1) ? 23 : $urandom_range(23);
        mi = $urandom_range(1) ? 59 : $urandom_range(59);
        sc = ($urandom_range(3) != 0) ? 59 : $urandom_range(59);
        return calendar_item(yr, mo, dy, hr, mi, sc);
    endfunction

    // ------------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------------
    // one item transfer; valid stays high into the next call when there is
    // no idle gap, so it is never lowered and raised in the same step
    task automatic send_item(input rtc_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        expected_readings.push_back(predict_reading(it));
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input rtc_pkg::cfg_index_t idx, input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rtc_pkg::CFG_TICKS_PER_SECOND: ticks_per_sec = value;
            rtc_pkg::CFG_BINARY_FORMAT:    binary_mode   = value[0];
            rtc_pkg::CFG_HOUR_24_FORMAT:   hour24_mode   = value[0];
            default:                       ;
        endcase
    endtask

    // stop sending and let every predicted reading come back, then allow
    // for the two-register pipeline to settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result checker: drives result_ready and compares every transfer
    // ------------------------------------------------------------------------
    initial
    begin : reading_checker
        rtc_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("result with nothing expected", result.tick_total, 0);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (result.cur_second !== want.cur_second)
                        report_mismatch("cur_second", result.cur_second, want.cur_second);
                    if (result.cur_minute !== want.cur_minute)
                        report_mismatch("cur_minute", result.cur_minute, want.cur_minute);
                    if (result.cur_hour !== want.cur_hour)
                        report_mismatch("cur_hour", result.cur_hour, want.cur_hour);
                    if (result.cur_day !== want.cur_day)
                        report_mismatch("cur_day", result.cur_day, want.cur_day);
                    if (result.cur_month !== want.cur_month)
                        report_mismatch("cur_month", result.cur_month, want.cur_month);
                    if (result.cur_year !== want.cur_year)
                        report_mismatch("cur_year", result.cur_year, want.cur_year);
                    if (result.elapsed_seconds !== want.elapsed_seconds)
                        report_mismatch("elapsed_seconds", result.elapsed_seconds,
                                        want.elapsed_seconds);
                    if (result.tick_total !== want.tick_total)
                        report_mismatch("tick_total", result.tick_total, want.tick_total);
                end
            end
            result_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold, counted here in cycles
    initial
    begin : receiver_hold
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                rx_hold <= 1'b1;
                repeat (hold_request) @(posedge clk);
                rx_hold <= 1'b0;
                hold_request = 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // default rate, a lowered rate equal to the running prescaler, largest rate
    task automatic test_prescaler();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) send_item(noise_item(rtc_pkg::OP_TICK));
        wait_idle();
        // prescaler already at 3, so the next tick completes a second
        write_reg(rtc_pkg::CFG_TICKS_PER_SECOND, 16'd3);
        send_item(noise_item(rtc_pkg::OP_TICK));
        wait_idle();
        write_reg(rtc_pkg::CFG_TICKS_PER_SECOND, 16'hFFFF);
        repeat (2) send_item(noise_item(rtc_pkg::OP_TICK));
        wait_idle();
    endtask

    // zero rate makes every tick a second; clamps, bad bcd and rollovers
    task automatic test_calendar_rollover();
        write_reg(rtc_pkg::CFG_TICKS_PER_SECOND, 16'd0);
        write_reg(rtc_pkg::CFG_BINARY_FORMAT, 16'd0);
        write_reg(rtc_pkg::CFG_HOUR_24_FORMAT, 16'd1);
        // year 9999 wraps to 0
        send_item(calendar_item(9999, 12, 31, 23, 59, 59));
        send_item(noise_item(rtc_pkg::OP_TICK));
        // all-zero bytes clamp day and month up, all-ones clamp everything down
        // and the hour with bit 7 set in 24-hour mode lands on 23
        send_item(load_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(load_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // invalid bcd digits decode arithmetically
        send_item(load_bytes(8'h1A, 8'h3F, 8'h1B, 8'h0C, 8'h0B, 8'h9F, 8'h1E));
        // leap by 400, not leap by 100, leap by 4
        send_item(calendar_item(2000, 2, 28, 23, 59, 59));
        send_item(noise_item(rtc_pkg::OP_TICK));
        send_item(calendar_item(1900, 2, 28, 23, 59, 59));
        send_item(noise_item(rtc_pkg::OP_TICK));
        send_item(calendar_item(2024, 2, 29, 23, 59, 59));
        send_item(noise_item(rtc_pkg::OP_TICK));
        // day 31 in a 30-day month rolls into the next month
        send_item(load_bytes(8'h59, 8'h59, 8'h23, 8'h31, 8'h04, 8'h21, 8'h20));
        send_item(noise_item(rtc_pkg::OP_TICK));
        wait_idle();
    endtask

    // 12-hour conversion in binary and bcd form
    task automatic test_twelve_hour_load();
        write_reg(rtc_pkg::CFG_BINARY_FORMAT, 16'd1);
        write_reg(rtc_pkg::CFG_HOUR_24_FORMAT, 16'd0);
        send_item(load_bytes(8'd0, 8'd0, 8'd12, 8'd1, 8'd1, 8'd24, 8'd20));
        send_item(load_bytes(8'd0, 8'd0, 8'h8C, 8'd1, 8'd1, 8'd24, 8'd20));
        send_item(load_bytes(8'd0, 8'd0, 8'h8B, 8'd1, 8'd1, 8'd24, 8'd20));
        wait_idle();
        write_reg(rtc_pkg::CFG_BINARY_FORMAT, 16'd0);
        send_item(load_bytes(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h24, 8'h20));
        send_item(load_bytes(8'h00, 8'h00, 8'h81, 8'h01, 8'h01, 8'h24, 8'h20));
        wait_idle();
    endtask

    // receiver holds off long enough for the block to fill and stall its
    // input, then the sender pauses until every reading is back
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(rtc_pkg::CFG_TICKS_PER_SECOND, 16'd2);
        write_reg(rtc_pkg::CFG_HOUR_24_FORMAT, 16'd1);
        hold_request = 300;
        repeat (60) send_item(random_item());
        wait_idle();
    endtask

    // random traffic across four register settings
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        logic [15:0] tps;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0:       tps = 16'd1;
                1:       tps = $urandom_range(2, 6);
                2:       tps = $urandom_range(7, 60);
                default: tps = $urandom_range(1) ? 16'hFFFF : $urandom_range(61, 65535);
            endcase
            write_reg(rtc_pkg::CFG_TICKS_PER_SECOND, tps);
            write_reg(rtc_pkg::CFG_BINARY_FORMAT, $urandom_range(1));
            write_reg(rtc_pkg::CFG_HOUR_24_FORMAT, $urandom_range(1));
            repeat (count / 4) send_item(random_item());
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_prescaler();
        test_calendar_rollover();
        test_twelve_hour_load();
        test_result_backpressure();
        test_random_traffic(320, 0, 0);
        test_random_traffic(320, 59, 0);
        test_random_traffic(320, 0, 59);
        test_random_traffic(320, 38, 38);

        if (expected_readings.size() != 0)
            report_mismatch("readings never returned", expected_readings.size(), 0);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // timeout, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
